// ===== hdl/slm_pkg.sv =====
package slm_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned FUNC_W  = 2;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_RUN    = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

endpackage

// ===== hdl/sorted_list_merge.sv =====
// load words (append to list a or b) are taken in idle, ready again the next cycle
// a run is accepted in idle, then each merged word passes an index fetch through
// the registered list ram read port, one shared signed compare, output register hold
// an empty run skips fetch and compare and shows a zero value marked last and empty
// synchronous active-low reset clears both counts and the sequencer; list ram
// contents are not cleared and only entries below the counts are ever used
module sorted_list_merge #(
    parameter int unsigned LIST_DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_func,
    input  logic signed [31:0]       i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [31:0]       o_merged_value,
    output logic                     o_last,
    output logic                     o_empty_res
);

    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
    localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    slm_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0]   r_i, n_i, r_j, n_j;
    slm_pkg::t_value r_out_value, n_out_value;
    logic            r_out_last, n_out_last;
    logic            r_out_empty, n_out_empty;

    logic            in_acc;
    logic            we_a, we_b;
    slm_pkg::t_value rd_a, rd_b;
    logic            a_has, b_has, take_a;
    slm_pkg::t_func  func;

    assign func   = slm_pkg::t_func'(i_func);
    assign in_acc = i_in_valid && o_in_ready;
    assign we_a   = in_acc && (func == slm_pkg::FUNC_LOAD_A) && (r_cnt_a < DEPTH_C);
    assign we_b   = in_acc && (func == slm_pkg::FUNC_LOAD_B) && (r_cnt_b < DEPTH_C);

    slm_ram #(.DEPTH(LIST_DEPTH), .AW(AW)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (rd_a)
    );

    slm_ram #(.DEPTH(LIST_DEPTH), .AW(AW)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (rd_b)
    );

    // shared compare, ties go to list a
    assign a_has  = r_i < r_cnt_a;
    assign b_has  = r_j < r_cnt_b;
    assign take_a = a_has && (!b_has || (rd_a <= rd_b));

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_i         = r_i;
        n_j         = r_j;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_empty = r_out_empty;
        unique case (r_state)
            slm_pkg::ST_IDLE: begin
                if (we_a) begin
                    n_cnt_a = r_cnt_a + ONE_C;
                end
                if (we_b) begin
                    n_cnt_b = r_cnt_b + ONE_C;
                end
                if (in_acc && (func == slm_pkg::FUNC_RUN)) begin
                    n_i = '0;
                    n_j = '0;
                    if ((r_cnt_a == '0) && (r_cnt_b == '0)) begin
                        n_out_value = '0;
                        n_out_last  = 1'b1;
                        n_out_empty = 1'b1;
                        n_state     = slm_pkg::ST_OUT;
                    end else begin
                        n_state = slm_pkg::ST_FETCH;
                    end
                end
            end
            slm_pkg::ST_FETCH: begin
                n_state = slm_pkg::ST_CMP;
            end
            slm_pkg::ST_CMP: begin
                n_out_empty = 1'b0;
                if (take_a) begin
                    n_out_value = rd_a;
                    n_out_last  = ((r_i + ONE_C) == r_cnt_a) && !b_has;
                    n_i         = r_i + ONE_C;
                end else begin
                    n_out_value = rd_b;
                    n_out_last  = ((r_j + ONE_C) == r_cnt_b) && !a_has;
                    n_j         = r_j + ONE_C;
                end
                n_state = slm_pkg::ST_OUT;
            end
            slm_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    if (r_out_last) begin
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_state = slm_pkg::ST_IDLE;
                    end else begin
                        n_state = slm_pkg::ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = slm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slm_pkg::ST_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
    end

    assign o_in_ready     = (r_state == slm_pkg::ST_IDLE);
    assign o_out_valid    = (r_state == slm_pkg::ST_OUT);
    assign o_merged_value = r_out_value;
    assign o_last         = r_out_last;
    assign o_empty_res    = r_out_empty;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a word waits at the output");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i <= r_cnt_a) && (r_j <= r_cnt_b) && (r_cnt_a <= DEPTH_C) && (r_cnt_b <= DEPTH_C))
        else $error("merge index or count out of range");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_res) |-> (o_last && (o_merged_value == '0)))
        else $error("empty result not marked last with zero value");

    a_clear_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> ((r_cnt_a == '0) && (r_cnt_b == '0)))
        else $error("counts not cleared after run");

    a_last_all_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last && !o_empty_res) |-> ((r_i == r_cnt_a) && (r_j == r_cnt_b)))
        else $error("last word shown before both lists are used up");

endmodule

// ===== hdl/slm_ram.sv =====
module slm_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  slm_pkg::t_value       i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output slm_pkg::t_value       o_rdata
);

    slm_pkg::t_value r_mem [DEPTH];
    slm_pkg::t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
